@@ design/hbhe_pkg.sv @@
package hbhe_pkg;

    localparam int HALF_W  = 33;
    localparam int TOTAL_W = 32;
    localparam int VAL_W   = 32;

    localparam logic [HALF_W-1:0]  HALF_MAX  = 33'h1_FFFF_FFFF;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = 32'hFFFF_FFFF;

    // operation codes
    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // placement codes
    localparam logic [2:0] PL_OUTSIDE = 3'd0;
    localparam logic [2:0] PL_END     = 3'd1;
    localparam logic [2:0] PL_SPLIT   = 3'd2;
    localparam logic [2:0] PL_WHOLE   = 3'd3;
    localparam logic [2:0] PL_NONE    = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_LOW_EDGE  = 2'd0;
    localparam logic [1:0] CFG_BIN_WIDTH = 2'd1;
    localparam logic [1:0] CFG_BINS_USED = 2'd2;

    typedef struct packed {
        logic cap;       // capture the item
        logic sweep;     // zero one bin and advance
        logic div_step;  // one quotient bit
        logic classify;  // place the sample
        logic modify;    // read-modify-write of one bin, or read result
        logic fin;       // load the result registers
    } t_cmd;

    typedef struct packed {
        logic op_add;     // incoming item is an add
        logic op_clear;   // incoming item is a clear
        logic sweep_last;
        logic div_last;
        logic in_domain;
        logic more;       // second bin of a split still to update
    } t_status;

    function automatic logic [HALF_W-1:0] sat_half(input logic [HALF_W-1:0] a,
                                                   input logic [1:0] inc);
        logic [HALF_W:0] s;
        s = {1'b0, a} + (HALF_W+1)'(inc);
        return (s > {1'b0, HALF_MAX}) ? HALF_MAX : s[HALF_W-1:0];
    endfunction

endpackage

@@ design/hbhe_ram.sv @@
module hbhe_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/hbhe_dp.sv @@
module hbhe_dp #(
    parameter int MAX_BINS = 256,
    localparam int AW  = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1,
    localparam int NBW = $clog2(MAX_BINS + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [1:0]                   i_cfg_idx,
    input  logic [31:0]                  i_cfg_wdata,
    input  logic [1:0]                   i_operation,
    input  logic signed [31:0]           i_sample,
    input  logic [7:0]                   i_bin_index,
    input  hbhe_pkg::t_cmd               i_cmd,
    output hbhe_pkg::t_status            o_status,
    output logic [hbhe_pkg::HALF_W-1:0]  o_bin_halves,
    output logic [hbhe_pkg::TOTAL_W-1:0] o_total_samples,
    output logic [hbhe_pkg::HALF_W-1:0]  o_domain_halves,
    output logic [2:0]                   o_placement,
    output logic [7:0]                   o_hit_bin
);

    // configuration
    logic signed [31:0] r_low_edge;
    logic [31:0]        r_bin_width;
    logic [8:0]         r_bins_used;

    // counters
    logic [hbhe_pkg::TOTAL_W-1:0] r_total;
    logic [hbhe_pkg::HALF_W-1:0]  r_domain;

    // item and working registers
    logic        r_op_add;
    logic        r_rd_ok;
    logic        r_neg;
    logic [31:0] r_quo;
    logic [31:0] r_rem;
    logic [4:0]  r_cnt;
    logic [AW-1:0] r_addr;
    logic [AW-1:0] r_q_addr;
    logic        r_two;
    logic [1:0]  r_inc;
    logic [hbhe_pkg::HALF_W-1:0] r_halves;
    logic [2:0]  r_place;
    logic [7:0]  r_hit;

    // result registers
    logic [hbhe_pkg::HALF_W-1:0]  r_out_halves;
    logic [hbhe_pkg::TOTAL_W-1:0] r_out_total;
    logic [hbhe_pkg::HALF_W-1:0]  r_out_domain;
    logic [2:0]                   r_out_place;
    logic [7:0]                   r_out_hit;

    logic [32:0]   w_offset;
    logic [31:0]   w_div;
    logic [32:0]   w_trial;
    logic          w_ge;
    logic [31:0]   w_rem_nx;
    logic [NBW-1:0] w_nb;
    logic [31:0]   w_nb_ext;
    logic          w_edge_lo;
    logic          w_edge_hi;
    logic          w_inner;
    logic          w_in_domain;
    logic [AW-1:0] w_target;
    logic [hbhe_pkg::HALF_W-1:0] w_rdata;
    logic [hbhe_pkg::HALF_W-1:0] w_sat;
    logic          w_we;
    logic [hbhe_pkg::HALF_W-1:0] w_wdata;

    assign w_offset = {i_sample[31], i_sample} - {r_low_edge[31], r_low_edge};
    assign w_div    = (r_bin_width == 32'd0) ? 32'd1 : r_bin_width;
    assign w_trial  = {r_rem, r_quo[31]};
    assign w_ge     = (w_trial >= {1'b0, w_div});
    assign w_rem_nx = w_ge ? 32'(w_trial - {1'b0, w_div}) : w_trial[31:0];

    always_comb begin
        if (r_bins_used == 9'd0) begin
            w_nb = NBW'(1);
        end else if (32'(r_bins_used) > 32'(MAX_BINS)) begin
            w_nb = NBW'(MAX_BINS);
        end else begin
            w_nb = NBW'(r_bins_used);
        end
    end

    assign w_nb_ext    = 32'(w_nb);
    assign w_edge_lo   = !r_neg && (r_quo == 32'd0) && (r_rem == 32'd0);
    assign w_edge_hi   = !r_neg && (r_quo == w_nb_ext) && (r_rem == 32'd0);
    assign w_inner     = !r_neg && (r_quo < w_nb_ext);
    assign w_in_domain = w_edge_lo || w_edge_hi || w_inner;

    always_comb begin
        if (w_edge_lo) begin
            w_target = '0;
        end else if (w_edge_hi) begin
            w_target = AW'(w_nb - NBW'(1));
        end else if (r_rem == 32'd0) begin
            w_target = AW'(r_quo - 32'd1);   // lower bin of a split first
        end else begin
            w_target = AW'(r_quo);
        end
    end

    assign w_sat   = hbhe_pkg::sat_half(w_rdata, r_inc);
    assign w_we    = i_cmd.sweep || (i_cmd.modify && r_op_add);
    assign w_wdata = i_cmd.sweep ? '0 : w_sat;

    hbhe_ram #(
        .WIDTH (hbhe_pkg::HALF_W),
        .DEPTH (MAX_BINS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_addr),
        .i_wdata (w_wdata),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    // configuration and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_edge  <= '0;
            r_bin_width <= 32'd1;
            r_bins_used <= 9'd256;
            r_total     <= '0;
            r_domain    <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    hbhe_pkg::CFG_LOW_EDGE:  r_low_edge  <= i_cfg_wdata;
                    hbhe_pkg::CFG_BIN_WIDTH: r_bin_width <= i_cfg_wdata;
                    hbhe_pkg::CFG_BINS_USED: r_bins_used <= i_cfg_wdata[8:0];
                    default: ;
                endcase
            end
            if (i_cmd.cap) begin
                if (i_operation == hbhe_pkg::OP_ADD) begin
                    if (r_total != hbhe_pkg::TOTAL_MAX) begin
                        r_total <= r_total + 32'd1;
                    end
                end else if (i_operation == hbhe_pkg::OP_CLEAR) begin
                    r_total  <= '0;
                    r_domain <= '0;
                end
            end
            if (i_cmd.classify && w_in_domain) begin
                r_domain <= hbhe_pkg::sat_half(r_domain,
                                               (w_edge_lo || w_edge_hi) ? 2'd1 : 2'd2);
            end
        end
    end

    // control-side working state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr   <= '0;
            r_two    <= 1'b0;
            r_op_add <= 1'b0;
            r_cnt    <= '0;
        end else begin
            if (i_cmd.cap) begin
                r_op_add <= (i_operation == hbhe_pkg::OP_ADD);
                r_two    <= 1'b0;
                r_cnt    <= '0;
                r_addr   <= (i_operation == hbhe_pkg::OP_CLEAR) ? '0 : AW'(i_bin_index);
            end
            if (i_cmd.sweep) begin
                r_addr <= r_addr + AW'(1);
            end
            if (i_cmd.div_step) begin
                r_cnt <= r_cnt + 5'd1;
            end
            if (i_cmd.classify) begin
                r_addr <= w_target;
                r_two  <= w_inner && !w_edge_lo && (r_rem == 32'd0);
            end
            if (i_cmd.modify && r_two) begin
                // advance to the upper bin of the split
                r_addr <= r_q_addr;
                r_two  <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_quo    <= w_offset[31:0];
            r_neg    <= w_offset[32];
            r_rem    <= '0;
            r_rd_ok  <= (32'(i_bin_index) < 32'(MAX_BINS));
            r_halves <= '0;
            r_place  <= (i_operation == hbhe_pkg::OP_ADD) ? hbhe_pkg::PL_OUTSIDE
                                                          : hbhe_pkg::PL_NONE;
            r_hit    <= (i_operation == hbhe_pkg::OP_ADD) ? 8'd0 : i_bin_index;
        end
        if (i_cmd.div_step) begin
            r_rem <= w_rem_nx;
            r_quo <= {r_quo[30:0], w_ge};
        end
        if (i_cmd.classify) begin
            r_q_addr <= AW'(r_quo);
            if (w_in_domain) begin
                if (w_edge_lo || w_edge_hi) begin
                    r_inc   <= 2'd1;
                    r_place <= hbhe_pkg::PL_END;
                    r_hit   <= 8'(w_target);
                end else if (r_rem == 32'd0) begin
                    r_inc   <= 2'd1;
                    r_place <= hbhe_pkg::PL_SPLIT;
                    r_hit   <= 8'(r_quo);
                end else begin
                    r_inc   <= 2'd2;
                    r_place <= hbhe_pkg::PL_WHOLE;
                    r_hit   <= 8'(r_quo);
                end
            end
        end
        if (i_cmd.modify) begin
            if (r_op_add) begin
                r_halves <= w_sat;
            end else begin
                r_halves <= r_rd_ok ? w_rdata : '0;
            end
        end
        if (i_cmd.fin) begin
            r_out_halves <= r_halves;
            r_out_total  <= r_total;
            r_out_domain <= r_domain;
            r_out_place  <= r_place;
            r_out_hit    <= r_hit;
        end
    end

    assign o_status.op_add     = (i_operation == hbhe_pkg::OP_ADD);
    assign o_status.op_clear   = (i_operation == hbhe_pkg::OP_CLEAR);
    assign o_status.sweep_last = (r_addr == AW'(MAX_BINS - 1));
    assign o_status.div_last   = (r_cnt == 5'd31);
    assign o_status.in_domain  = w_in_domain;
    assign o_status.more       = r_op_add && r_two;

    assign o_bin_halves    = r_out_halves;
    assign o_total_samples = r_out_total;
    assign o_domain_halves = r_out_domain;
    assign o_placement     = r_out_place;
    assign o_hit_bin       = r_out_hit;

`ifndef SYNTH
    a_no_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.modify && r_op_add) |-> (w_sat >= w_rdata))
        else $error("bin update wrapped");

    a_target_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.classify && w_in_domain) |=> (32'(r_addr) < w_nb_ext))
        else $error("bin address past active bins");
`endif

endmodule

@@ design/hbhe_ctrl.sv @@
module hbhe_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  hbhe_pkg::t_status i_status,
    output hbhe_pkg::t_cmd    o_cmd,
    output logic              o_busy,
    output logic              o_valid
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SWEEP = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_CLASS = 3'd3;
    localparam logic [2:0] S_RD    = 3'd4;
    localparam logic [2:0] S_MOD   = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_clr;
    logic       n_clr;
    logic       r_valid;

    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.cap = 1'b1;
                    if (i_status.op_add) begin
                        n_state = S_DIV;
                    end else if (i_status.op_clear) begin
                        n_clr   = 1'b1;
                        n_state = S_SWEEP;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_SWEEP: begin
                o_cmd.sweep = 1'b1;
                if (i_status.sweep_last) begin
                    // the sweep after reset gives no item
                    n_state = r_clr ? S_FIN : S_IDLE;
                    n_clr   = 1'b0;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_CLASS;
                end
            end
            S_CLASS: begin
                o_cmd.classify = 1'b1;
                n_state = i_status.in_domain ? S_RD : S_FIN;
            end
            S_RD: begin
                n_state = S_MOD;
            end
            S_MOD: begin
                o_cmd.modify = 1'b1;
                n_state = i_status.more ? S_RD : S_FIN;
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SWEEP;
            r_clr   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_valid <= o_cmd.fin;
        end
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = r_valid;

`ifndef SYNTH
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |=> !r_valid)
        else $error("result strobe longer than one cycle");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && r_state == S_IDLE) |=> (r_state != S_IDLE))
        else $error("accepted item did not start");

    a_strobe_after_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_state == S_IDLE))
        else $error("result strobe while still working");
`endif

endmodule

@@ design/histogram_binning_half_edge_top.sv @@
// From accept to o_valid, an add runs the 32-step serial divider, classifies the sample and
// then does the bin read-modify-write (twice for a split edge, skipped when outside);
// a read fetches one bin; a clear sweeps every bin, one bin zeroed a cycle.
// One item at a time: busy drops in the cycle the result is shown.
// Reset (synchronous, active low) zeroes the counters and then sweeps the bin store
// with busy high; the receiver cannot stall results.
module histogram_binning_half_edge_top #(
    parameter int MAX_BINS = 256
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [1:0]                   i_cfg_idx,
    input  logic [31:0]                  i_cfg_wdata,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   i_operation,
    input  logic signed [31:0]           i_sample,
    input  logic [7:0]                   i_bin_index,
    output logic                         o_valid,
    output logic [hbhe_pkg::HALF_W-1:0]  o_bin_halves,
    output logic [hbhe_pkg::TOTAL_W-1:0] o_total_samples,
    output logic [hbhe_pkg::HALF_W-1:0]  o_domain_halves,
    output logic [2:0]                   o_placement,
    output logic [7:0]                   o_hit_bin
);

    hbhe_pkg::t_cmd    w_cmd;
    hbhe_pkg::t_status w_status;

    hbhe_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_busy   (busy),
        .o_valid  (o_valid)
    );

    hbhe_dp #(
        .MAX_BINS (MAX_BINS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_operation     (i_operation),
        .i_sample        (i_sample),
        .i_bin_index     (i_bin_index),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .o_bin_halves    (o_bin_halves),
        .o_total_samples (o_total_samples),
        .o_domain_halves (o_domain_halves),
        .o_placement     (o_placement),
        .o_hit_bin       (o_hit_bin)
    );

endmodule
